>>> rtl/sysrs_pkg.sv
// Shared types and constants for the systematic resampler.
package sysrs_pkg;

   localparam int PARTICLES_DEF = 64;
   localparam int WEIGHT_W      = 16;
   localparam int OFFSET_W      = 16;
   localparam int TOTAL_W       = 22;
   localparam int INDEX_W       = 6;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic [OFFSET_W-1:0] offset;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] slot;
      logic [INDEX_W-1:0] source_index;
      logic               fresh;
      logic               final_res;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MUL,
      ST_READ,
      ST_SCALE,
      ST_CMP,
      ST_EMIT
   } state_type;

endpackage

>>> rtl/sysrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sysrs_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/systematic_resampler.sv
// Systematic resampler: weight load into a cumulative-sum RAM, then a draw pass.
//
//   channel   dir  handshake               payload
//   req_      in   req_valid / req_ready   req_type: weight, offset, last
//   rsp_      out  rsp_valid / rsp_ready   rsp_type: slot, source_index, fresh, final_res
//
// Load: one weight per cycle; req_ready is high only in the load state.
// Draw: offset*total first, then a RAM read and a scale for the first compare;
//   each advance of the source pointer takes a RAM read, scale and compare, and
//   each slot a compare and an emit; a zero total emits every slot with no compare.
// The single comparator and the single RAM read port set this order of steps.
// Reset clears the state, the running total and the load count; no RAM clear.
// A stalled rsp_ready holds the current result and the whole draw pass.
module systematic_resampler import sysrs_pkg::*; #(
   parameter int PARTICLES = PARTICLES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
   localparam int JW = $clog2(PARTICLES + 1);
   localparam int LW = TOTAL_W + JW;
   localparam int CW = LW + 16;
   localparam int PW = OFFSET_W + TOTAL_W;
   localparam logic [JW-1:0] J_END     = JW'(PARTICLES);
   localparam logic [JW-1:0] J_TOP     = JW'(PARTICLES - 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(PARTICLES - 1);

   state_type          state_ff, state_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [JW-1:0]      count_ff, count_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [CW-1:0]      rhs_ff, rhs_in;
   logic [LW-1:0]      lhs_ff, lhs_in;
   logic [AW-1:0]      i_ff, i_in;
   logic [JW-1:0]      j_ff, j_in;
   logic [AW-1:0]      src_ff, src_in;

   logic               req_fire;
   logic               wr_en;
   logic [TOTAL_W-1:0] sum;
   logic [TOTAL_W-1:0] rd_data;
   logic [TOTAL_W-1:0] cum_sel;
   logic [PW-1:0]      start_prod;
   logic               less;
   logic               total_zero;

   assign req_ready  = (state_ff == ST_LOAD);
   assign rsp_valid  = (state_ff == ST_EMIT);
   assign req_fire   = req_valid && req_ready;
   assign wr_en      = req_fire && (count_ff < J_END);
   assign sum        = total_ff + TOTAL_W'(req_data.weight);
   assign cum_sel    = (j_ff < count_ff) ? rd_data : total_ff;
   assign start_prod = offset_ff * total_ff;
   assign less       = {lhs_ff, 16'h0000} < rhs_ff;
   assign total_zero = (total_ff == '0);

   sysrs_ram #(
      .WIDTH(TOTAL_W),
      .DEPTH(PARTICLES)
   ) u_cum_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(sum),
      .rd_addr(j_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      total_in  = total_ff;
      count_in  = count_ff;
      offset_in = offset_ff;
      rhs_in    = rhs_ff;
      lhs_in    = lhs_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      src_in    = src_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (wr_en) begin
               total_in = sum;
               count_in = count_ff + 1'b1;
            end
            if (req_fire && req_data.last) begin
               offset_in = req_data.offset;
               i_in      = '0;
               j_in      = '0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            rhs_in = CW'(start_prod);
            if (total_zero) begin
               src_in   = i_ff;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            lhs_in   = LW'(cum_sel) * LW'(PARTICLES);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if ((j_ff < J_END) && less) begin
               j_in = j_ff + 1'b1;
               // clamp when the pointer runs off the end
               if (j_ff == J_TOP) begin
                  src_in   = LAST_SLOT;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_READ;
               end
            end else begin
               src_in   = (j_ff >= J_END) ? LAST_SLOT : j_ff[AW-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (i_ff == LAST_SLOT) begin
                  total_in = '0;
                  count_in = '0;
                  state_in = ST_LOAD;
               end else begin
                  i_in   = AW'(i_ff + 1'b1);
                  rhs_in = rhs_ff + (CW'(total_ff) << 16);
                  if (total_zero) begin
                     src_in   = AW'(i_ff + 1'b1);
                     state_in = ST_EMIT;
                  end else begin
                     // lhs still holds the scaled sum at j: compare again
                     state_in = ST_CMP;
                  end
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         total_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      rhs_ff    <= rhs_in;
      lhs_ff    <= lhs_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      src_ff    <= src_in;
   end

   assign rsp_data.slot         = INDEX_W'(i_ff);
   assign rsp_data.source_index = INDEX_W'(src_ff);
   assign rsp_data.fresh        = (i_ff == '0);
   assign rsp_data.final_res    = (i_ff == LAST_SLOT);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted during draw pass");

   a_src_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.source_index < PARTICLES))
      else $error("source index out of range");

   a_pass_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.final_res) |=> (req_ready && count_ff == '0))
      else $error("draw pass did not return to load");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= J_END)
      else $error("load count past particle count");

   a_next_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.final_res) |=>
         (rsp_data.slot == $past(rsp_data.slot) + 1'b1))
      else $error("slot did not advance by one");

endmodule
